/* rtl/multilevel_queue_scheduler_assert.svh */
// Assertion macros for the scheduler checker.
`ifndef MULTILEVEL_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define MLQS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MLQS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mlqs_pkg.sv */
package mlqs_pkg;

	localparam int TIME_W = 16;
	localparam int ID_W   = 8;

	localparam logic [TIME_W-1:0] IDLE_LIMIT_RESET = 16'd1000;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_STEP  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [2:0] EV_LOADED     = 3'd0;
	localparam logic [2:0] EV_IDLE_TICK  = 3'd1;
	localparam logic [2:0] EV_SYS_RAN    = 3'd2;
	localparam logic [2:0] EV_USER_TICK  = 3'd3;
	localparam logic [2:0] EV_ALL_DONE   = 3'd4;
	localparam logic [2:0] EV_IDLE_LIMIT = 3'd5;
	localparam logic [2:0] EV_TABLE_FULL = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] remaining;
		logic              user;
	} entry_t;

	typedef struct packed {
		logic   any_work;
		logic   sys_found;
		logic   usr_found;
		entry_t sys_ent;
		entry_t usr_ent;
	} scan_res_t;

endpackage

/* rtl/mlqs_table.sv */
module mlqs_table import mlqs_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/mlqs_scan.sv */
module mlqs_scan import mlqs_pkg::*; #(
	parameter int IDX_W     = 6,
	parameter int TIME_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 init,
	input  logic                 ent_vld,
	input  entry_t               ent,
	input  logic [IDX_W-1:0]     ent_idx,
	input  logic [TIME_BITS-1:0] cur_time,
	output scan_res_t            res,
	output logic [IDX_W-1:0]     sys_idx,
	output logic [IDX_W-1:0]     usr_idx
);

	localparam int CMP_W = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;

	logic   has_work;
	logic   ready;
	logic   take_sys;
	logic   take_usr;
	logic   any_work_q;
	logic   sys_found_q;
	logic   usr_found_q;
	entry_t sys_ent_q;
	entry_t usr_ent_q;

	assign has_work = (ent.remaining != '0);
	assign ready    = has_work && (CMP_W'(ent.arrival) <= CMP_W'(cur_time));
	assign take_sys = ent_vld && ready && !ent.user &&
		(!sys_found_q || (ent.arrival < sys_ent_q.arrival));
	assign take_usr = ent_vld && ready && ent.user &&
		(!usr_found_q || (ent.arrival < usr_ent_q.arrival));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_work_q  <= 1'b0;
			sys_found_q <= 1'b0;
			usr_found_q <= 1'b0;
		end else if (init) begin
			any_work_q  <= 1'b0;
			sys_found_q <= 1'b0;
			usr_found_q <= 1'b0;
		end else begin
			if (ent_vld && has_work) begin
				any_work_q <= 1'b1;
			end
			if (take_sys) begin
				sys_found_q <= 1'b1;
			end
			if (take_usr) begin
				usr_found_q <= 1'b1;
			end
		end
	end

	// best-so-far payload
	always_ff @(posedge clk) begin
		if (take_sys) begin
			sys_ent_q <= ent;
			sys_idx   <= ent_idx;
		end
		if (take_usr) begin
			usr_ent_q <= ent;
			usr_idx   <= ent_idx;
		end
	end

	assign res.any_work  = any_work_q;
	assign res.sys_found = sys_found_q;
	assign res.usr_found = usr_found_q;
	assign res.sys_ent   = sys_ent_q;
	assign res.usr_ent   = usr_ent_q;

endmodule

/* rtl/multilevel_queue_scheduler.sv */
// Two-level (system / user) process scheduler over a loaded table.
// Command channel: drive start with mode and the load fields; the command
// transaction is taken on a clock edge with start high and busy low.
// Mode load appends one entry, mode step makes one scheduling decision,
// mode clear empties the table and zeroes time; mode 3 is dropped silently.
// Each load, step or clear gives one result: done is high for one cycle
// with event_res, ran_id, start_time and end_time; the receiver cannot stall it.
// Load, clear and a step while halted: result one cycle after the edge,
// busy stays low, so a command may follow on the next cycle.
// Step: busy through the scan and decide states; the table, with separate read
// and write ports, is read one entry a cycle by the scan unit, then if work
// is left the decide state updates time through the saturating adder and
// writes back any chosen entry. Result comes with the edge that drops busy.
// idle_limit is written through cfg_we / cfg_wdata; the user must do so only while idle.
// Reset: empty table, time 0, not halted, idle_limit 1000.
module multilevel_queue_scheduler import mlqs_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int TIME_BITS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        mode,
	input  logic [ID_W-1:0]   process_id,
	input  logic [TIME_W-1:0] arrival_time,
	input  logic [TIME_W-1:0] burst_time,
	input  logic              is_user,
	output logic              done,
	output logic [2:0]        event_res,
	output logic [ID_W-1:0]   ran_id,
	output logic [TIME_W-1:0] start_time,
	output logic [TIME_W-1:0] end_time,
	input  logic              cfg_we,
	input  logic [TIME_W-1:0] cfg_wdata
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
	localparam int SUM_W = CMP_W + 1;
	localparam logic [SUM_W-1:0] TIME_MAX_EXT =
		{{(SUM_W - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     scan_idx_q;
	logic [TIME_BITS-1:0] time_q;
	logic                 halted_q;
	logic [TIME_W-1:0]    idle_limit_q;
	logic                 rd_pend_s1;
	logic [IDX_W-1:0]     rd_idx_s1;

	logic              accept;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	logic              rd_en;
	entry_t            rd_data;
	logic              scan_init;
	logic              scan_more;
	scan_res_t         scan_res;
	logic [IDX_W-1:0]  sys_idx;
	logic [IDX_W-1:0]  usr_idx;
	logic              count_inc;
	logic              table_clr;
	logic              time_ld;
	logic              halt_set;
	logic              res_load;
	logic [2:0]        res_ev;
	logic [ID_W-1:0]   res_id;
	logic [TIME_W-1:0] res_start;
	logic [TIME_W-1:0] res_end;

	logic [TIME_W-1:0]    add_b;
	logic [SUM_W-1:0]     sum_full;
	logic [TIME_BITS-1:0] time_sat;
	logic                 limit_hit;
	entry_t               load_ent;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign scan_more = (scan_idx_q < count_q);

	assign load_ent.id        = process_id;
	assign load_ent.arrival   = arrival_time;
	assign load_ent.remaining = burst_time;
	assign load_ent.user      = is_user;

	// shared saturating time adder
	assign add_b     = scan_res.sys_found ? scan_res.sys_ent.remaining : TIME_W'(1);
	assign sum_full  = SUM_W'(time_q) + SUM_W'(add_b);
	assign time_sat  = (sum_full > TIME_MAX_EXT) ? {TIME_BITS{1'b1}}
		: sum_full[TIME_BITS-1:0];
	assign limit_hit = (CMP_W'(time_sat) >= CMP_W'(idle_limit_q));

	mlqs_table #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	mlqs_scan #(
		.IDX_W     (IDX_W),
		.TIME_BITS (TIME_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.init     (scan_init),
		.ent_vld  (rd_pend_s1),
		.ent      (rd_data),
		.ent_idx  (rd_idx_s1),
		.cur_time (time_q),
		.res      (scan_res),
		.sys_idx  (sys_idx),
		.usr_idx  (usr_idx)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (mode == MODE_STEP) && !halted_q) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// last entry is folded in at the edge that leaves this state
				if (!scan_more) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = count_q[IDX_W-1:0];
		wr_data   = load_ent;
		rd_en     = 1'b0;
		scan_init = 1'b0;
		count_inc = 1'b0;
		table_clr = 1'b0;
		time_ld   = 1'b0;
		halt_set  = 1'b0;
		res_load  = 1'b0;
		res_ev    = EV_LOADED;
		res_id    = '0;
		res_start = TIME_W'(time_q);
		res_end   = TIME_W'(time_q);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (mode)
						MODE_LOAD: begin
							res_load = 1'b1;
							if (count_q == CNT_W'(TABLE_DEPTH)) begin
								res_ev = EV_TABLE_FULL;
							end else begin
								wr_en     = 1'b1;
								count_inc = 1'b1;
							end
						end
						MODE_STEP: begin
							if (halted_q) begin
								res_load = 1'b1;
								res_ev   = EV_IDLE_LIMIT;
							end else begin
								scan_init = 1'b1;
							end
						end
						MODE_CLEAR: begin
							res_load  = 1'b1;
							table_clr = 1'b1;
							res_start = '0;
							res_end   = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				rd_en = scan_more;
			end
			ST_DECIDE: begin
				res_load = 1'b1;
				if (!scan_res.any_work) begin
					res_ev = EV_ALL_DONE;
				end else begin
					time_ld = 1'b1;
					res_end = TIME_W'(time_sat);
					if (scan_res.sys_found) begin
						wr_en             = 1'b1;
						wr_addr           = sys_idx;
						wr_data           = scan_res.sys_ent;
						wr_data.remaining = '0;
						res_ev            = EV_SYS_RAN;
						res_id            = scan_res.sys_ent.id;
					end else if (scan_res.usr_found) begin
						wr_en             = 1'b1;
						wr_addr           = usr_idx;
						wr_data           = scan_res.usr_ent;
						wr_data.remaining = scan_res.usr_ent.remaining - TIME_W'(1);
						res_ev            = EV_USER_TICK;
						res_id            = scan_res.usr_ent.id;
					end else if (limit_hit) begin
						halt_set = 1'b1;
						res_ev   = EV_IDLE_LIMIT;
					end else begin
						res_ev = EV_IDLE_TICK;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			scan_idx_q   <= '0;
			time_q       <= '0;
			halted_q     <= 1'b0;
			idle_limit_q <= IDLE_LIMIT_RESET;
			rd_pend_s1   <= 1'b0;
			done         <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= rd_en;
			done       <= res_load;
			if (cfg_we) begin
				idle_limit_q <= cfg_wdata;
			end
			if (table_clr) begin
				count_q <= '0;
			end else if (count_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (scan_init) begin
				scan_idx_q <= '0;
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			if (table_clr) begin
				time_q <= '0;
			end else if (time_ld) begin
				time_q <= time_sat;
			end
			if (table_clr) begin
				halted_q <= 1'b0;
			end else if (halt_set) begin
				halted_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
		if (res_load) begin
			event_res  <= res_ev;
			ran_id     <= res_id;
			start_time <= res_start;
			end_time   <= res_end;
		end
	end

endmodule

/* rtl/mlqs_checker.sv */
`include "multilevel_queue_scheduler_assert.svh"

module mlqs_checker import mlqs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [1:0]        mode,
	input logic              done,
	input logic [2:0]        event_res,
	input logic [ID_W-1:0]   ran_id,
	input logic [TIME_W-1:0] start_time,
	input logic [TIME_W-1:0] end_time
);

	`MLQS_ASSERT_NEXT(a_load_result, start && !busy && (mode == MODE_LOAD), done && !busy, "load transaction gave no result on the next cycle")
	`MLQS_ASSERT_NEXT(a_step_progress, start && !busy && (mode == MODE_STEP), busy || done, "step transaction neither started nor finished")
	`MLQS_ASSERT_NOW(a_ran_id_zero, done && (event_res != EV_SYS_RAN) && (event_res != EV_USER_TICK), ran_id == '0, "ran_id set for an event without a run")
	`MLQS_ASSERT_NOW(a_all_done_time, done && (event_res == EV_ALL_DONE), end_time == start_time, "time moved on an all-done step")

endmodule

bind multilevel_queue_scheduler mlqs_checker u_mlqs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.mode       (mode),
	.done       (done),
	.event_res  (event_res),
	.ran_id     (ran_id),
	.start_time (start_time),
	.end_time   (end_time)
);

/* verif/tb_multilevel_queue_scheduler.sv */
`timescale 1ns / 100ps

module tb_multilevel_queue_scheduler;
	import mlqs_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ID_W-1:0]   pid;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic              user;
	} sched_cmd_t;

	typedef struct packed {
		logic [2:0]        ev;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] t_start;
		logic [TIME_W-1:0] t_end;
	} sched_event_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        mode = MODE_LOAD;
	logic [ID_W-1:0]   process_id = '0;
	logic [TIME_W-1:0] arrival_time = '0;
	logic [TIME_W-1:0] burst_time = '0;
	logic              is_user = 1'b0;
	logic              done;
	logic [2:0]        event_res;
	logic [ID_W-1:0]   ran_id;
	logic [TIME_W-1:0] start_time;
	logic [TIME_W-1:0] end_time;
	logic              cfg_we = 1'b0;
	logic [TIME_W-1:0] cfg_wdata = '0;

	// scheduler image
	logic [ID_W-1:0]   tbl_id        [DEPTH];
	logic [TIME_W-1:0] tbl_arrival   [DEPTH];
	logic [TIME_W-1:0] tbl_remaining [DEPTH];
	logic              tbl_user      [DEPTH];
	int                tbl_count = 0;
	logic [TIME_W-1:0] sched_time = '0;
	logic              sched_halted = 1'b0;
	logic [TIME_W-1:0] idle_limit = IDLE_LIMIT_RESET;

	sched_cmd_t   pending_cmds[$];
	sched_event_t expected_events[$];
	sched_cmd_t   cur_cmd = '0;
	sched_cmd_t   next_cmd;
	sched_event_t oldest_event;
	int           gap_left = 0;
	logic         gaps_on = 1'b1;
	int           failures = 0;

	multilevel_queue_scheduler #(
		.TABLE_DEPTH(DEPTH),
		.TIME_BITS  (TIME_W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.process_id  (process_id),
		.arrival_time(arrival_time),
		.burst_time  (burst_time),
		.is_user     (is_user),
		.done        (done),
		.event_res   (event_res),
		.ran_id      (ran_id),
		.start_time  (start_time),
		.end_time    (end_time),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] sum;
		sum = a + b;
		return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
	endfunction

	// earliest-arrived ready entry of one class, ties to earlier load; -1 if none
	function automatic int earliest_ready(input logic cls);
		int best;
		best = -1;
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_user[i] != cls || tbl_remaining[i] == 0 || tbl_arrival[i] > sched_time)
				continue;
			if (best < 0 || tbl_arrival[i] < tbl_arrival[best])
				best = i;
		end
		return best;
	endfunction

	task automatic predict_decision(input sched_cmd_t c);
		sched_event_t e;
		int           sys_idx;
		int           usr_idx;
		logic         work_left;
		if (c.mode == MODE_UNUSED)
			return;
		e = '0;
		e.t_start = sched_time;
		case (c.mode)
		MODE_CLEAR: begin
			tbl_count = 0;
			sched_time = '0;
			sched_halted = 1'b0;
			e.ev = EV_LOADED;
			e.t_start = '0;
		end
		MODE_LOAD: begin
			if (tbl_count >= DEPTH) begin
				e.ev = EV_TABLE_FULL;
			end else begin
				tbl_id[tbl_count] = c.pid;
				tbl_arrival[tbl_count] = c.arrival;
				tbl_remaining[tbl_count] = c.burst;
				tbl_user[tbl_count] = c.user;
				tbl_count++;
				e.ev = EV_LOADED;
			end
		end
		MODE_STEP: begin
			if (sched_halted) begin
				e.ev = EV_IDLE_LIMIT;
			end else begin
				work_left = 1'b0;
				for (int i = 0; i < tbl_count; i++)
					if (tbl_remaining[i] != 0)
						work_left = 1'b1;
				sys_idx = earliest_ready(1'b0);
				usr_idx = earliest_ready(1'b1);
				if (!work_left) begin
					e.ev = EV_ALL_DONE;
				end else if (sys_idx >= 0) begin
					sched_time = sat_add(sched_time, tbl_remaining[sys_idx]);
					tbl_remaining[sys_idx] = '0;
					e.id = tbl_id[sys_idx];
					e.ev = EV_SYS_RAN;
				end else if (usr_idx >= 0) begin
					tbl_remaining[usr_idx] = tbl_remaining[usr_idx] - TIME_W'(1);
					sched_time = sat_add(sched_time, TIME_W'(1));
					e.id = tbl_id[usr_idx];
					e.ev = EV_USER_TICK;
				end else begin
					sched_time = sat_add(sched_time, TIME_W'(1));
					if (sched_time >= idle_limit) begin
						sched_halted = 1'b1;
						e.ev = EV_IDLE_LIMIT;
					end else begin
						e.ev = EV_IDLE_TICK;
					end
				end
			end
		end
		default: ;
		endcase
		e.t_end = sched_time;
		expected_events.push_back(e);
	endtask

	// command driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				predict_decision(cur_cmd);
			if (!start || !busy) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_cmds.size() != 0 && gaps_on && $urandom_range(0, 5) == 0) begin
					gap_left <= $urandom_range(0, 6);
					start <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					next_cmd = pending_cmds.pop_front();
					cur_cmd <= next_cmd;
					mode <= next_cmd.mode;
					process_id <= next_cmd.pid;
					arrival_time <= next_cmd.arrival;
					burst_time <= next_cmd.burst;
					is_user <= next_cmd.user;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_events.size() == 0) begin
				$error("unexpected transaction: event_res %0d ran_id %0d start_time %0d end_time %0d",
					event_res, ran_id, start_time, end_time);
				failures++;
			end else begin
				oldest_event = expected_events.pop_front();
				if (event_res !== oldest_event.ev) begin
					$error("event_res: expected %0d, got %0d", oldest_event.ev, event_res);
					failures++;
				end
				if (ran_id !== oldest_event.id) begin
					$error("ran_id: expected %0d, got %0d", oldest_event.id, ran_id);
					failures++;
				end
				if (start_time !== oldest_event.t_start) begin
					$error("start_time: expected %0d, got %0d", oldest_event.t_start, start_time);
					failures++;
				end
				if (end_time !== oldest_event.t_end) begin
					$error("end_time: expected %0d, got %0d", oldest_event.t_end, end_time);
					failures++;
				end
			end
		end
	end

	task automatic push_cmd(input logic [1:0] m, input logic [ID_W-1:0] pid,
		input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] bur, input logic usr);
		sched_cmd_t c;
		c.mode = m;
		c.pid = pid;
		c.arrival = arr;
		c.burst = bur;
		c.user = usr;
		pending_cmds.push_back(c);
	endtask

	task automatic push_random(input logic [1:0] m);
		push_cmd(m, ID_W'($urandom), TIME_W'($urandom), TIME_W'($urandom), 1'($urandom));
	endtask

	task automatic push_random_load();
		logic [TIME_W-1:0] arr;
		logic [TIME_W-1:0] bur;
		case ($urandom_range(0, 9))
		0: arr = TIME_W'($urandom);
		1: arr = TIME_MAX;
		default: arr = TIME_W'($urandom_range(0, 20));
		endcase
		case ($urandom_range(0, 11))
		0: bur = '0;
		1: bur = TIME_W'($urandom);
		2: bur = TIME_MAX;
		default: bur = TIME_W'($urandom_range(1, 6));
		endcase
		push_cmd(MODE_LOAD, ID_W'($urandom), arr, bur, 1'($urandom));
	endtask

	// clear, fill, then mostly steps with some loads, clears and noise mixed in
	task automatic push_session(inout int sent);
		int n_load;
		int n_step;
		if ($urandom_range(0, 19) == 0) begin
			n_load = DEPTH + $urandom_range(1, 3);
			n_step = $urandom_range(2, 5);
		end else begin
			n_load = $urandom_range(1, 8);
			n_step = $urandom_range(3, 24);
		end
		push_random(MODE_CLEAR);
		sent++;
		repeat (n_load) begin
			push_random_load();
			sent++;
		end
		repeat (n_step) begin
			case ($urandom_range(0, 29))
			0, 1: begin
				push_random_load();
				sent++;
			end
			2: push_random(MODE_UNUSED);
			3: begin
				push_random(MODE_CLEAR);
				sent++;
			end
			default: begin
				push_random(MODE_STEP);
				sent++;
			end
			endcase
		end
	endtask

	task automatic run_random(input int n_items);
		int sent;
		sent = 0;
		while (sent < n_items)
			push_session(sent);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_cmds.size() != 0 || start || expected_events.size() != 0)
			@(negedge clk);
		repeat (DEPTH + 8) @(negedge clk);
	endtask

	task automatic set_idle_limit(input logic [TIME_W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		idle_limit = value;
		@(negedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_random(MODE_STEP);
		push_cmd(MODE_UNUSED, '1, '1, '1, 1'b1);
		push_cmd(MODE_LOAD, 8'hFF, 16'd0, 16'd3, 1'b0);
		push_cmd(MODE_LOAD, 8'h00, 16'd0, 16'd2, 1'b1);
		push_cmd(MODE_LOAD, 8'h5A, 16'd0, 16'd1, 1'b1);
		push_cmd(MODE_LOAD, 8'hA5, TIME_MAX, 16'd0, 1'b0);
		push_cmd(MODE_LOAD, 8'h01, 16'd4, TIME_MAX, 1'b0);
		repeat (6) push_random(MODE_STEP);
		push_cmd(MODE_CLEAR, '1, '1, '1, 1'b1);
		// system run carries time past the limit, the next idle tick halts
		push_cmd(MODE_LOAD, 8'h02, 16'd0, 16'd2000, 1'b0);
		push_cmd(MODE_LOAD, 8'h03, 16'd3000, 16'd1, 1'b1);
		repeat (3) push_random(MODE_STEP);
		push_cmd(MODE_LOAD, 8'h04, 16'd0, 16'd1, 1'b1);
		push_random(MODE_CLEAR);
		push_cmd(MODE_LOAD, 8'h09, 16'd2, 16'd1, 1'b1);
		repeat (4) push_random(MODE_STEP);

		set_idle_limit(16'd1);
		run_random(200);
		set_idle_limit(TIME_MAX);
		run_random(200);
		set_idle_limit(TIME_W'($urandom_range(2, 40)));
		run_random(300);
		set_idle_limit(TIME_W'($urandom_range(5, 60)));
		run_random(250);
		set_idle_limit(TIME_W'($urandom_range(1, 30)));
		gaps_on = 1'b0;
		run_random(150);

		wait_drained();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$error("timeout: %0d commands pending, %0d results outstanding",
			pending_cmds.size(), expected_events.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
